>>> hw/rtl/phtt_pkg.sv
package phtt_pkg;

    localparam int OwnerWidth = 8;
    localparam int CountWidth = 15;
    localparam int RawWidth   = 16;

    typedef struct packed {
        logic                  valid;
        logic [OwnerWidth-1:0] owner;
        logic [CountWidth-1:0] period;
        logic [CountWidth-1:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_REJECT = 3'd1,
        STS_FULL   = 3'd2,
        STS_FIRED  = 3'd3,
        STS_NONE   = 3'd4
    } t_status;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

>>> hw/rtl/phtt_cell.sv
module phtt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  phtt_pkg::t_entry i_entry,
    output phtt_pkg::t_entry o_entry
);
    import phtt_pkg::*;

    logic                  r_valid;
    logic [OwnerWidth-1:0] r_owner;
    logic [CountWidth-1:0] r_period;
    logic [CountWidth-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_owner  <= i_entry.owner;
            r_period <= i_entry.period;
            r_count  <= i_entry.count;
        end
    end

    assign o_entry = '{valid: r_valid, owner: r_owner, period: r_period, count: r_count};

endmodule

>>> hw/rtl/phtt_ctrl.sv
module phtt_ctrl #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [7:0]       i_object_id,
    input  logic [15:0]      i_interval,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_fired_object_id,
    output logic             o_last_result,
    input  phtt_pkg::t_entry i_head,
    input  phtt_pkg::t_entry i_next,
    output phtt_pkg::t_entry o_tail,
    output logic             o_shift
);
    import phtt_pkg::*;

    localparam int StepWidth = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [StepWidth-1:0] LastStep = StepWidth'(TABLE_ENTRIES - 1);

    t_state                r_state, n_state;
    logic [StepWidth-1:0]  r_step, n_step;
    t_op                   r_op, n_op;
    logic [OwnerWidth-1:0] r_id, n_id;
    logic [RawWidth-1:0]   r_raw, n_raw;
    logic                  r_done, n_done;
    logic                  r_rmv, n_rmv;
    t_status               r_status, n_status;
    logic                  r_pend_v, n_pend_v;
    logic [OwnerWidth-1:0] r_pend_id, n_pend_id;
    logic                  r_o_valid, n_o_valid;
    t_status               r_o_status, n_o_status;
    logic [OwnerWidth-1:0] r_o_id, n_o_id;
    logic                  r_o_last, n_o_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_last;
    logic                  w_match;
    logic                  w_fire;
    logic                  w_adv;
    logic                  w_zero;
    logic                  w_neg;
    logic [CountWidth-1:0] w_mag;
    logic [CountWidth-1:0] w_new_period;
    t_entry                w_fill;
    t_status               w_final;

    assign w_zero       = (r_raw == '0);
    assign w_neg        = r_raw[RawWidth-1];
    assign w_mag        = r_raw[CountWidth-1:0];
    assign w_new_period = w_neg ? CountWidth'(1) : w_mag;
    assign w_last       = (r_step == LastStep);
    assign w_match      = i_head.valid && (i_head.owner == r_id);
    assign w_fire       = i_head.valid && (i_head.count <= CountWidth'(1));
    assign w_out_free   = !r_o_valid || !i_stall;
    assign w_adv        = !((r_op == OP_TICK) && w_fire && r_pend_v && !w_out_free);
    assign w_accept     = i_valid && (r_state == S_IDLE);
    assign w_fill       = w_last ? t_entry'('0) : i_next;
    assign w_final      = r_done ? r_status : (w_zero ? STS_OK : STS_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_RUN;
            end
            S_RUN: begin
                if (w_adv && w_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs to the chain
    always_comb begin
        o_stall = (r_state != S_IDLE);
        o_shift = (r_state == S_RUN) && w_adv;
        o_tail  = i_head;
        if (r_op == OP_TICK) begin
            if (i_head.valid) begin
                o_tail.count = w_fire ? i_head.period : (i_head.count - CountWidth'(1));
            end
        end else if (r_rmv) begin
            o_tail = w_fill;
        end else if (!r_done && w_match) begin
            if (w_zero) begin
                o_tail = w_fill;
            end else if (!w_neg) begin
                o_tail.period = w_mag;
                o_tail.count  = w_mag;
            end
        end else if (!r_done && !i_head.valid && !w_zero) begin
            o_tail = '{valid: 1'b1, owner: r_id, period: w_new_period,
                       count: w_new_period};
        end
    end

    // sequencing registers and result beats
    always_comb begin
        n_step     = r_step;
        n_op       = r_op;
        n_id       = r_id;
        n_raw      = r_raw;
        n_done     = r_done;
        n_rmv      = r_rmv;
        n_status   = r_status;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_id     = r_o_id;
        n_o_last   = r_o_last;
        if (w_accept) begin
            n_step   = '0;
            n_op     = t_op'(i_operation);
            n_id     = i_object_id;
            n_raw    = i_interval;
            n_done   = 1'b0;
            n_rmv    = 1'b0;
            n_pend_v = 1'b0;
        end
        if (o_shift) begin
            n_step = r_step + StepWidth'(1);
            if (r_op == OP_TICK) begin
                if (w_fire) begin
                    if (r_pend_v) begin
                        n_o_valid  = 1'b1;
                        n_o_status = STS_FIRED;
                        n_o_id     = r_pend_id;
                        n_o_last   = 1'b0;
                    end
                    n_pend_v  = 1'b1;
                    n_pend_id = i_head.owner;
                end
            end else if (!r_done) begin
                if (w_match) begin
                    n_done   = 1'b1;
                    n_rmv    = w_zero;
                    n_status = (!w_zero && w_neg) ? STS_REJECT : STS_OK;
                end else if (!i_head.valid) begin
                    n_done   = 1'b1;
                    n_status = STS_OK;
                end
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            n_o_valid = 1'b1;
            n_o_last  = 1'b1;
            n_pend_v  = 1'b0;
            if (r_op == OP_TICK) begin
                n_o_status = r_pend_v ? STS_FIRED : STS_NONE;
                n_o_id     = r_pend_v ? r_pend_id : '0;
            end else begin
                n_o_status = w_final;
                n_o_id     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend_v  <= n_pend_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_op       <= n_op;
        r_id       <= n_id;
        r_raw      <= n_raw;
        r_done     <= n_done;
        r_rmv      <= n_rmv;
        r_status   <= n_status;
        r_pend_id  <= n_pend_id;
        r_o_status <= n_o_status;
        r_o_id     <= n_o_id;
        r_o_last   <= n_o_last;
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_fired_object_id = r_o_id;
    assign o_last_result     = r_o_last;

endmodule

>>> hw/rtl/periodic_heartbeat_timer_table.sv
// Table of up to TABLE_ENTRIES periodic timers kept in insertion order in a ring of cells.
// Every item, set or tick, rotates the ring once past a single processing point at the
// head, one entry per cycle unless a firing tick must wait for the output side to take
// a waiting result beat. Each item is taken, rotates the ring through every cell and hands
// over its final beat before the next input beat is accepted; an output-side hold-off of a
// waiting result beat delays it further. A removal closes the gap during that rotation by
// feeding the tail from the cell behind the head. Ids are taken as 8-bit values directly.
module periodic_heartbeat_timer_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_object_id,
    input  logic [15:0] i_interval,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_fired_object_id,
    output logic        o_last_result
);
    import phtt_pkg::*;

    t_entry w_entry [0:TABLE_ENTRIES];
    t_entry w_tail;
    logic   w_shift;

    assign w_entry[TABLE_ENTRIES] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        phtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry ((g == TABLE_ENTRIES - 1) ? w_tail : w_entry[g + 1]),
            .o_entry (w_entry[g])
        );
    end

    phtt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_object_id       (i_object_id),
        .i_interval        (i_interval),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_fired_object_id (o_fired_object_id),
        .o_last_result     (o_last_result),
        .i_head            (w_entry[0]),
        .i_next            (w_entry[1]),
        .o_tail            (w_tail),
        .o_shift           (w_shift)
    );

endmodule

>>> sim/periodic_heartbeat_timer_table_test.sv
`timescale 1ns / 1ps

module periodic_heartbeat_timer_table_test;
    import phtt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

    typedef struct {
        t_op         op;
        logic [7:0]  id;
        logic [15:0] interval;
    } t_request;

    typedef struct {
        t_status    status;
        logic [7:0] id;
        logic       last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_operation = 1'b0;
    logic [7:0]  i_object_id = 8'h00;
    logic [15:0] i_interval = 16'h0000;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [7:0]  o_fired_object_id;
    logic        o_last_result;

    t_request pending_requests[$];
    t_beat    awaited_beats[$];
    t_request offered;
    t_beat    seen;

    bit          tbl_valid [TABLE_DEPTH] = '{default: 1'b0};
    logic [7:0]  tbl_owner [TABLE_DEPTH];
    logic [14:0] tbl_period [TABLE_DEPTH];
    logic [14:0] tbl_count [TABLE_DEPTH];

    int send_idle_pct = 14;
    int recv_idle_pct = 83;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    bit hold_served = 1'b0;

    periodic_heartbeat_timer_table #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_object_id(i_object_id),
        .i_interval(i_interval),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_fired_object_id(o_fired_object_id),
        .o_last_result(o_last_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     awaited_beats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void add_expected(input t_beat beat);
        awaited_beats = {awaited_beats, beat};
    endfunction

    function automatic void add_pending(input t_request req);
        pending_requests = {pending_requests, req};
    endfunction

    function automatic void advance_table(input t_request req);
        int          hit;
        int          used;
        bit          have_held;
        t_beat       held;
        t_status     status;
        logic [14:0] load;
        hit = -1;
        used = 0;
        have_held = 1'b0;
        status = STS_OK;
        if (req.op == OP_TICK) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (!tbl_valid[k]) continue;
                if (tbl_count[k] <= 15'd1) begin
                    tbl_count[k] = tbl_period[k];
                    if (have_held) add_expected(held);
                    held = '{STS_FIRED, tbl_owner[k], 1'b0};
                    have_held = 1'b1;
                end else begin
                    tbl_count[k] = tbl_count[k] - 15'd1;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                add_expected(held);
            end else begin
                add_expected('{STS_NONE, 8'h00, 1'b1});
            end
            return;
        end
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (tbl_valid[k] && tbl_owner[k] == req.id && hit < 0) hit = k;
            if (tbl_valid[k]) used++;
        end
        if (req.interval == 16'h0000) begin
            if (hit >= 0) begin
                for (int k = hit; k < TABLE_DEPTH - 1; k++) begin
                    tbl_valid[k] = tbl_valid[k + 1];
                    tbl_owner[k] = tbl_owner[k + 1];
                    tbl_period[k] = tbl_period[k + 1];
                    tbl_count[k] = tbl_count[k + 1];
                end
                tbl_valid[TABLE_DEPTH - 1] = 1'b0;
            end
        end else if (hit >= 0) begin
            if (req.interval[15]) begin
                status = STS_REJECT;
            end else begin
                tbl_period[hit] = req.interval[14:0];
                tbl_count[hit] = req.interval[14:0];
            end
        end else if (used >= TABLE_DEPTH) begin
            status = STS_FULL;
        end else begin
            load = req.interval[15] ? 15'd1 : req.interval[14:0];
            tbl_valid[used] = 1'b1;
            tbl_owner[used] = req.id;
            tbl_period[used] = load;
            tbl_count[used] = load;
        end
        add_expected('{status, 8'h00, 1'b1});
    endfunction

    function automatic t_request random_request();
        t_request req;
        int       r;
        req.op = ($urandom_range(99) < 35) ? OP_TICK : OP_SET;
        req.id = ($urandom_range(99) < 85) ? 8'(8'h40 + $urandom_range(23))
                                            : 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 15) begin
            req.interval = 16'h0000;
        end else if (r < 27) begin
            req.interval = 16'($urandom_range(65535, 32768));
        end else if (r < 87) begin
            req.interval = 16'($urandom_range(8, 1));
        end else begin
            req.interval = 16'($urandom_range(32767, 1));
        end
        return req;
    endfunction

    task automatic queue_set(input logic [7:0] id, input logic [15:0] interval);
        add_pending('{OP_SET, id, interval});
    endtask

    task automatic queue_tick();
        add_pending('{OP_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535))});
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++) add_pending(random_request());
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_valid || awaited_beats.size() > 0)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) advance_table(offered);
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_requests.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= offered.op;
                    i_object_id <= offered.id;
                    i_interval <= offered.interval;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output-side stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_beats.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat status %0d id %0d last %0b",
                                        o_status, o_fired_object_id, o_last_result));
            end else begin
                seen = awaited_beats.pop_front();
                if (o_status !== seen.status)
                    flag_mismatch($sformatf("status %0d, want %0d", o_status, seen.status));
                if (o_fired_object_id !== seen.id)
                    flag_mismatch($sformatf("fired id %0d, want %0d", o_fired_object_id,
                                            seen.id));
                if (o_last_result !== seen.last)
                    flag_mismatch($sformatf("last %0b, want %0b", o_last_result, seen.last));
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_request && !hold_served) begin
            hold_served <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, insert, clamp, reject, reload, remove
        queue_tick();
        queue_set(8'h00, 16'd1);
        queue_set(8'hFF, 16'h8000);
        queue_set(8'h55, 16'h7FFF);
        queue_set(8'h00, 16'hFFFF);
        queue_set(8'h00, 16'd2);
        queue_tick();
        queue_set(8'h33, 16'h0000);
        queue_set(8'h00, 16'h0000);
        // fill to capacity, then overflow
        for (int k = 0; k < 13; k++) queue_set(8'(8'hA0 + k), 16'(k + 1));
        queue_set(8'h0F, 16'd3);
        queue_set(8'hF0, 16'd5);
        queue_tick();
        queue_random(100);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 14;
        queue_random(100);
        hold_request = 1'b1;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(85);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && awaited_beats.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", mismatches,
                     awaited_beats.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
